// ===== design/foc_sine_phase_voltage_assert.svh =====
// Assertion macros for the sine phase voltage block and its sine unit.
// Needs clk_i and rst_ni in the scope that uses the macros.
`ifndef FOC_SINE_PHASE_VOLTAGE_ASSERT_SVH
`define FOC_SINE_PHASE_VOLTAGE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define FSPV_ASSERT_IMP(name, cond, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error("fspv assertion failed");
`define FSPV_ASSERT_NXT(name, cond, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error("fspv assertion failed");
`else
`define FSPV_ASSERT_IMP(name, cond, prop)
`define FSPV_ASSERT_NXT(name, cond, prop)
`endif
`endif

// ===== design/fspv_pkg.sv =====
// Package for the sine phase voltage block: types, constants, register indexes
// and the sine table entry function. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fspv_pkg;

  localparam int unsigned ANGLE_BITS_DEF         = 16;
  localparam int unsigned SINE_TABLE_ENTRIES_DEF = 256;

  localparam logic signed [15:0] SQRT3_HALF_Q15 = 16'sd28378;

  localparam logic [5:0]  POLE_PAIRS_RST   = 6'd1;
  localparam logic        DIRECTION_RST    = 1'b0;
  localparam logic [15:0] ZERO_OFFSET_RST  = 16'd0;
  localparam logic [13:0] SUPPLY_LIMIT_RST = 14'd6144;

  typedef enum logic [1:0] {
    CFG_POLE_PAIRS   = 2'd0,
    CFG_DIRECTION    = 2'd1,
    CFG_ZERO_OFFSET  = 2'd2,
    CFG_SUPPLY_LIMIT = 2'd3
  } fspv_cfg_e;

  typedef struct packed {
    logic signed [16:0] sin_v;
    logic signed [16:0] cos_v;
  } fspv_sincos_t;

  // Sine of x (Q30 radians) by a truncated Taylor series, rounded to Q15.
  function automatic logic [15:0] sine_q15(input longint unsigned x);
    longint unsigned x2;
    longint unsigned t3;
    longint unsigned t5;
    longint unsigned t7;
    longint unsigned t9;
    longint unsigned s;
    x2 = (x * x) >> 30;
    t3 = ((x * x2) >> 30) / 64'd6;
    t5 = ((t3 * x2) >> 30) / 64'd20;
    t7 = ((t5 * x2) >> 30) / 64'd42;
    t9 = ((t7 * x2) >> 30) / 64'd72;
    s  = x - t3 + t5 - t7 + t9;
    return 16'((s + 64'd16384) >> 15);
  endfunction

endpackage

`default_nettype wire

// ===== design/fspv_sine_unit.sv =====
// Three-stage sine and cosine unit: quadrant folding, quarter-wave table
// lookup and linear interpolation. Depends on fspv_pkg and the assertion header.
`timescale 1ns / 1ps
`default_nettype none
`include "foc_sine_phase_voltage_assert.svh"

module fspv_sine_unit import fspv_pkg::*; #(
  parameter int unsigned ANGLE_BITS         = ANGLE_BITS_DEF,
  parameter int unsigned SINE_TABLE_ENTRIES = SINE_TABLE_ENTRIES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [ANGLE_BITS-1:0] angle_i,
  output fspv_sincos_t          sincos_o
);

  localparam int unsigned QB = ANGLE_BITS - 2;
  localparam int unsigned IW = $clog2(SINE_TABLE_ENTRIES + 1);
  localparam int unsigned PW = QB + IW + 1;
  localparam int unsigned MW = QB + 16;
  localparam logic [IW-1:0] LAST = IW'(SINE_TABLE_ENTRIES);
  localparam logic [QB:0]   QUARTER = {1'b1, {QB{1'b0}}};

  logic [15:0] rom_w [SINE_TABLE_ENTRIES+1];

  for (genvar k = 0; k <= SINE_TABLE_ENTRIES; k++) begin : g_rom
    localparam longint unsigned X = (64'd1686629713 * k) / SINE_TABLE_ENTRIES;
    assign rom_w[k] = sine_q15(X);
  end

  logic [1:0]    quad_w;
  logic [QB-1:0] part_w;
  logic          mir_w [2];
  logic          neg_w [2];
  logic [QB:0]   u_w   [2];
  logic [PW-1:0] pos_w [2];
  logic [IW:0]   ii_w  [2];

  logic [IW-1:0] idx_q   [2];
  logic [QB-1:0] frac_q  [2];
  logic          neg2_q  [2];
  logic [15:0]   lo_q    [2];
  logic [15:0]   diff_q  [2];
  logic [QB-1:0] frac3_q [2];
  logic          neg3_q  [2];
  logic [IW-1:0] hi_w    [2];
  logic [MW-1:0] prod_w  [2];
  logic [16:0]   mag_w   [2];
  logic signed [16:0] val_q [2];

  assign quad_w = angle_i[ANGLE_BITS-1 -: 2];
  assign part_w = angle_i[QB-1:0];

  // Lane 0 is the sine, lane 1 the cosine (angle plus a quarter turn).
  assign mir_w[0] = quad_w[0];
  assign neg_w[0] = quad_w[1];
  assign mir_w[1] = ~quad_w[0];
  assign neg_w[1] = quad_w[1] ^ quad_w[0];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      u_w[l]    = mir_w[l] ? (QUARTER - {1'b0, part_w}) : {1'b0, part_w};
      pos_w[l]  = PW'(u_w[l]) * PW'(SINE_TABLE_ENTRIES);
      ii_w[l]   = pos_w[l][PW-1:QB];
      hi_w[l]   = (idx_q[l] == LAST) ? LAST : idx_q[l] + IW'(1);
      prod_w[l] = MW'(diff_q[l]) * MW'(frac3_q[l]);
      mag_w[l]  = {1'b0, lo_q[l] + 16'(prod_w[l] >> QB)};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 2; l++) begin
      if (ii_w[l] >= (IW + 1)'(SINE_TABLE_ENTRIES)) begin
        idx_q[l]  <= LAST;
        frac_q[l] <= '0;
      end else begin
        idx_q[l]  <= ii_w[l][IW-1:0];
        frac_q[l] <= pos_w[l][QB-1:0];
      end
      neg2_q[l]  <= neg_w[l];
      lo_q[l]    <= rom_w[idx_q[l]];
      diff_q[l]  <= rom_w[hi_w[l]] - rom_w[idx_q[l]];
      frac3_q[l] <= frac_q[l];
      neg3_q[l]  <= neg2_q[l];
      val_q[l]   <= neg3_q[l] ? -signed'(mag_w[l]) : signed'(mag_w[l]);
    end
  end

  assign sincos_o.sin_v = val_q[0];
  assign sincos_o.cos_v = val_q[1];

  `FSPV_ASSERT_IMP(a_sin_end_no_frac, idx_q[0] == LAST, frac_q[0] == '0)
  `FSPV_ASSERT_IMP(a_cos_end_no_frac, idx_q[1] == LAST, frac_q[1] == '0)
  `FSPV_ASSERT_NXT(a_sin_end_flat, idx_q[0] == LAST, diff_q[0] == '0)

endmodule

`default_nettype wire

// ===== design/foc_sine_phase_voltage.sv =====
// Top level of the field-oriented sine modulation pipeline.
// Depends on fspv_pkg, fspv_sine_unit and the assertion header.
`timescale 1ns / 1ps
`default_nettype none
`include "foc_sine_phase_voltage_assert.svh"

// Usage:
// A word (angle, angle_is_electrical, volt_q, volt_d) is taken at each rising
// edge where start_i is high and busy_o is low. busy_o stays low: the pipeline
// takes one word every cycle.
// Each word yields one result (three phase voltages, the electrical angle and
// the clipped flag), shown for a single cycle with done_o high. The receiver
// cannot hold results off, and none is needed.
// The 9 stages are: electrical angle, quadrant folding and table position,
// table lookup, interpolation, the four Park products, the Park sums, the
// sqrt(3)/2 product, the Clarke sums with the centre, and rounding with
// saturation.
// Configuration is written through cfg_we_i, cfg_addr_i and cfg_data_i, with
// no wait, while no word is in flight.
// Reset clears the valid bits and loads the default register values: one pole
// pair, normal direction, zero offset, a supply limit of 24 volts.

module foc_sine_phase_voltage import fspv_pkg::*; #(
  parameter int unsigned ANGLE_BITS         = ANGLE_BITS_DEF,
  parameter int unsigned SINE_TABLE_ENTRIES = SINE_TABLE_ENTRIES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [15:0]        angle_i,
  input  logic               angle_is_electrical_i,
  input  logic signed [13:0] volt_q_i,
  input  logic signed [13:0] volt_d_i,
  output logic               done_o,
  output logic signed [15:0] phase_a_o,
  output logic signed [15:0] phase_b_o,
  output logic signed [15:0] phase_c_o,
  output logic [15:0]        electrical_angle_o,
  output logic               clipped_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_addr_i,
  input  logic [15:0]        cfg_data_i
);

  localparam int unsigned AB       = ANGLE_BITS;
  localparam int unsigned PRW      = AB + 6;
  localparam int unsigned SINE_LAT = 3;
  localparam int unsigned LAT      = 9;

  logic [5:0]  pole_q;
  logic        rev_q;
  logic [15:0] zero_q;
  logic [13:0] supply_q;

  logic accept_w;
  logic [LAT-1:0] valid_q;

  logic [AB-1:0]  ang_w;
  logic [PRW-1:0] prod_full_w;
  logic [AB-1:0]  prod_w;
  logic [AB-1:0]  dir_w;
  logic [AB-1:0]  el_d;
  logic [AB-1:0]  el_q;

  logic signed [13:0] vq_q [SINE_LAT+1];
  logic signed [13:0] vd_q [SINE_LAT+1];
  logic [15:0]        elo_q [LAT];

  fspv_sincos_t sc_w;

  logic signed [30:0] pcd_q, psq_q, psd_q, pcq_q;
  logic signed [31:0] a23_q, b23_q, a23_7_q;
  logic signed [47:0] bm_q;
  logic signed [47:0] cen_w, ash15_w, ash14_w;
  logic signed [47:0] ua_q, ub_q, uc_q;
  logic [16:0]        sa_w, sb_w, sc_sat_w;
  logic signed [15:0] pa_q, pb_q, pc_q;
  logic               clip_q;

  function automatic logic [16:0] sat16(input logic signed [17:0] v);
    logic [16:0] r;
    if (v > 18'sd32767) begin
      r = {1'b1, 16'h7FFF};
    end else if (v < -18'sd32768) begin
      r = {1'b1, 16'h8000};
    end else begin
      r = {1'b0, v[15:0]};
    end
    return r;
  endfunction

  assign busy_o   = 1'b0;
  assign accept_w = start_i & ~busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pole_q   <= POLE_PAIRS_RST;
      rev_q    <= DIRECTION_RST;
      zero_q   <= ZERO_OFFSET_RST;
      supply_q <= SUPPLY_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (fspv_cfg_e'(cfg_addr_i))
        CFG_POLE_PAIRS:   pole_q   <= cfg_data_i[5:0];
        CFG_DIRECTION:    rev_q    <= cfg_data_i[0];
        CFG_ZERO_OFFSET:  zero_q   <= cfg_data_i;
        CFG_SUPPLY_LIMIT: supply_q <= cfg_data_i[13:0];
        default:          pole_q   <= pole_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[LAT-2:0], accept_w};
    end
  end

  // Electrical angle, one turn: as given, or dir * poles * angle - offset.
  assign ang_w       = AB'(angle_i);
  assign prod_full_w = PRW'(pole_q) * PRW'(ang_w);
  assign prod_w      = prod_full_w[AB-1:0];
  assign dir_w       = rev_q ? (AB'(0) - prod_w) : prod_w;
  assign el_d        = angle_is_electrical_i ? ang_w : (dir_w - AB'(zero_q));

  fspv_sine_unit #(
    .ANGLE_BITS        (ANGLE_BITS),
    .SINE_TABLE_ENTRIES(SINE_TABLE_ENTRIES)
  ) u_sine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .angle_i (el_q),
    .sincos_o(sc_w)
  );

  assign cen_w   = signed'((48'(supply_q) << 29) + (48'd1 << 29));
  assign ash15_w = 48'(a23_7_q) <<< 15;
  assign ash14_w = 48'(a23_7_q) <<< 14;

  assign sa_w     = sat16(18'(ua_q >>> 30));
  assign sb_w     = sat16(18'(ub_q >>> 30));
  assign sc_sat_w = sat16(18'(uc_q >>> 30));

  always_ff @(posedge clk_i) begin
    el_q     <= el_d;
    elo_q[0] <= 16'(el_d);
    vq_q[0]  <= volt_q_i;
    vd_q[0]  <= volt_d_i;
    for (int i = 1; i <= SINE_LAT; i++) begin
      vq_q[i] <= vq_q[i-1];
      vd_q[i] <= vd_q[i-1];
    end
    for (int i = 1; i < LAT; i++) begin
      elo_q[i] <= elo_q[i-1];
    end
    pcd_q   <= sc_w.cos_v * vd_q[SINE_LAT];
    psq_q   <= sc_w.sin_v * vq_q[SINE_LAT];
    psd_q   <= sc_w.sin_v * vd_q[SINE_LAT];
    pcq_q   <= sc_w.cos_v * vq_q[SINE_LAT];
    a23_q   <= 32'(pcd_q) - 32'(psq_q);
    b23_q   <= 32'(psd_q) + 32'(pcq_q);
    a23_7_q <= a23_q;
    bm_q    <= 48'(b23_q) * 48'(SQRT3_HALF_Q15);
    ua_q    <= ash15_w + cen_w;
    ub_q    <= bm_q - ash14_w + cen_w;
    uc_q    <= cen_w - ash14_w - bm_q;
    pa_q    <= sa_w[15:0];
    pb_q    <= sb_w[15:0];
    pc_q    <= sc_sat_w[15:0];
    clip_q  <= sa_w[16] | sb_w[16] | sc_sat_w[16];
  end

  assign done_o             = valid_q[LAT-1];
  assign phase_a_o          = pa_q;
  assign phase_b_o          = pb_q;
  assign phase_c_o          = pc_q;
  assign electrical_angle_o = elo_q[LAT-1];
  assign clipped_o          = clip_q;

  `FSPV_ASSERT_IMP(a_done_follows_start, done_o, $past(accept_w, LAT))
  `FSPV_ASSERT_IMP(a_elec_passthrough,
      done_o && $past(accept_w && angle_is_electrical_i, LAT),
      electrical_angle_o == 16'(AB'($past(angle_i, LAT))))
  `FSPV_ASSERT_IMP(a_clip_at_rail, done_o && clipped_o,
      phase_a_o == 16'sh7FFF || phase_a_o == -16'sh8000 ||
      phase_b_o == 16'sh7FFF || phase_b_o == -16'sh8000 ||
      phase_c_o == 16'sh7FFF || phase_c_o == -16'sh8000)

endmodule

`default_nettype wire
